@@ design/triangle_edge_setup_defines.svh @@
// Assertion helpers for the triangle edge setup block.
`ifndef TRIANGLE_EDGE_SETUP_DEFINES_SVH
`define TRIANGLE_EDGE_SETUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle_edge_setup: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle_edge_setup: next-cycle check failed");

`endif

@@ design/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, constants and helpers of the triangle edge setup block.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_ROW = 2'd0;
  localparam logic [1:0] REG_MAX_ROW = 2'd1;

  localparam logic signed [15:0] MIN_ROW_RESET = 16'sd0;
  localparam logic signed [15:0] MAX_ROW_RESET = 16'sd4095;

  typedef enum logic [2:0] {
    S_IN,
    S_DIV,
    S_WAIT,
    S_MUL,
    S_ADD,
    S_OUT
  } tes_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [15:0] sat16(input logic signed [33:0] v);
    logic [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/tes_div.sv @@
// ----------------------------------------------------------------------------
// tes_div
// Restoring divider, one quotient bit per cycle, saturated signed result.
// ----------------------------------------------------------------------------
module tes_div import tes_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [33+FRAC_BITS-1:0] num,
  input  logic [32:0]             den,
  input  logic                    neg,
  output div_stat_t               stat,
  output logic [31:0]             quot
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [NW-1:0] quo;
  logic          neg_r;
  logic [33:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      neg_r <= neg;
    end else if (busy) begin
      rem <= fits ? 33'(trial - {1'b0, den}) : trial[32:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = (quo > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo[31:0];
    end else begin
      quot = (quo > NW'(33'h080000000)) ? 32'h80000000 : 32'(-quo[31:0]);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ design/triangle_edge_setup.sv @@
// Vertices one and two are held as they are taken. The third vertex yields the
// left edge and then the right edge. Their steps come from one shared restoring
// divider of NW = 33+FRAC_BITS quotient bits, one quotient bit a cycle. No vertex
// is taken until both edge words have left. Reset is synchronous: clip rows
// return to 0 and 4095, the vertex count to zero.
// ----------------------------------------------------------------------------
// triangle_edge_setup
// Edge setup for flat-top and flat-bottom triangles, with top clipping and bottom row clamping.
// ----------------------------------------------------------------------------
module triangle_edge_setup import tes_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        shape,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] depth_z,
  input  logic [31:0] clip_w,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        edge_side,
  output logic [15:0] start_row,
  output logic [15:0] end_row,
  output logic [31:0] start_x,
  output logic [31:0] start_z,
  output logic [31:0] start_w,
  output logic [31:0] step_x,
  output logic [31:0] step_z,
  output logic [31:0] step_w,
  output logic [15:0] rows_clipped,
  output logic        degenerate,
  output logic        last
);

  `include "triangle_edge_setup_defines.svh"

  localparam logic signed [33:0] ONE_M1 = (34'sd1 <<< FRAC_BITS) - 34'sd1;

  tes_state_t state, state_next;

  logic signed [15:0] min_row, max_row;
  logic [63:0]        held_xy [0:1];
  logic [63:0]        held_zw [0:1];
  logic [1:0]         vertex_count;
  logic [31:0]        x2, y2, z2, w2;
  logic               shape_r;
  logic               side;
  logic [1:0]         comp;
  logic signed [33:0] top_c, bot_c, clip_amt;
  logic [31:0]        step_v  [0:2];
  logic [31:0]        start_v [0:2];
  logic signed [64:0] prod;

  logic               in_acc, out_acc, third;
  logic signed [31:0] y0, y1;
  logic signed [33:0] top_calc, bot_calc, min_ext, max_ext;
  logic signed [31:0] p0, p1, p2, s_val, e_val;
  logic signed [32:0] diff, dy;
  logic [32:0]        diff_mag, dy_mag;
  logic               degen, div_start;
  div_stat_t          div_stat;
  logic [31:0]        div_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IN);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign third     = (vertex_count >= 2'd2);

  assign y0 = held_xy[0][31:0];
  assign y1 = held_xy[1][31:0];
  assign top_calc = ($signed({{2{y0[31]}}, y0}) + ONE_M1) >>> FRAC_BITS;
  assign bot_calc = (($signed({{2{y1[31]}}, y1}) + ONE_M1) >>> FRAC_BITS) - 34'sd1;
  assign min_ext  = 34'(min_row);
  assign max_ext  = 34'(max_row);

  // Component select: x, z, then w of each vertex.
  always_comb begin
    case (comp)
      2'd0: begin
        p0 = held_xy[0][63:32]; p1 = held_xy[1][63:32]; p2 = x2;
      end
      2'd1: begin
        p0 = held_zw[0][63:32]; p1 = held_zw[1][63:32]; p2 = z2;
      end
      default: begin
        p0 = held_zw[0][31:0];  p1 = held_zw[1][31:0];  p2 = w2;
      end
    endcase
  end

  // The right edge of a flat-top triangle runs from the third vertex down.
  always_comb begin
    if (!side) begin
      s_val = p0;
      e_val = p1;
      dy    = 33'(y1) - 33'(y0);
    end else if (!shape_r) begin
      s_val = p0;
      e_val = p2;
      dy    = 33'(signed'(y2)) - 33'(y0);
    end else begin
      s_val = p2;
      e_val = p1;
      dy    = 33'(y1) - 33'(signed'(y2));
    end
  end

  assign diff     = 33'(e_val) - 33'(s_val);
  assign diff_mag = diff[32] ? 33'(-diff) : diff;
  assign dy_mag   = dy[32] ? 33'(-dy) : dy;
  assign degen    = (dy == 33'sd0);

  tes_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({diff_mag, FRAC_BITS'(0)}),
    .den   (dy_mag),
    .neg   (diff[32] ^ dy[32]),
    .stat  (div_stat),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IN: begin
        if (in_acc && third) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (degen) begin
          state_next = (comp == 2'd2) ? S_MUL : S_DIV;
        end else begin
          div_start  = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_stat.done) begin
          state_next = (comp == 2'd2) ? S_MUL : S_DIV;
        end
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        state_next = (comp == 2'd2) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (out_acc) begin
          state_next = side ? S_IN : S_DIV;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_row      <= MIN_ROW_RESET;
      max_row      <= MAX_ROW_RESET;
      vertex_count <= 2'd0;
      side         <= 1'b0;
      comp         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_ROW: min_row <= cfg_data;
          REG_MAX_ROW: max_row <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        vertex_count <= third ? 2'd0 : vertex_count + 2'd1;
        side         <= 1'b0;
        comp         <= 2'd0;
      end
      if ((state == S_DIV && degen) || (state == S_WAIT && div_stat.done) ||
          state == S_ADD) begin
        comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      end
      if (out_acc) begin
        side <= 1'b1;
        comp <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!third) begin
        held_xy[vertex_count[0]] <= {pos_x, pos_y};
        held_zw[vertex_count[0]] <= {depth_z, clip_w};
      end else begin
        x2      <= pos_x;
        y2      <= pos_y;
        z2      <= depth_z;
        w2      <= clip_w;
        shape_r <= shape;
        if (top_calc < min_ext) begin
          clip_amt <= min_ext - top_calc;
          top_c    <= min_ext;
        end else begin
          clip_amt <= 34'sd0;
          top_c    <= top_calc;
        end
        bot_c <= (bot_calc > max_ext) ? max_ext : bot_calc;
      end
    end
    if (state == S_DIV && degen) begin
      step_v[comp] <= 32'd0;
    end
    if (state == S_WAIT && div_stat.done) begin
      step_v[comp] <= div_q;
    end
    if (state == S_MUL) begin
      prod <= $signed(step_v[comp]) * $signed(clip_amt[32:0]);
    end
    if (state == S_ADD) begin
      start_v[comp] <= sat32(66'(s_val) + 66'(prod));
    end
  end

  assign edge_side    = side;
  assign last         = side;
  assign start_row    = sat16(top_c);
  assign end_row      = sat16(bot_c);
  assign start_x      = start_v[0];
  assign start_z      = start_v[1];
  assign start_w      = start_v[2];
  assign step_x       = step_v[0];
  assign step_z       = step_v[1];
  assign step_w       = step_v[2];
  assign rows_clipped = (clip_amt > 34'sd65535) ? 16'hFFFF : clip_amt[15:0];
  assign degenerate   = degen;

  `TES_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall)
  `TES_ASSERT_NOW(a_div_in_wait, div_stat.busy, state == S_WAIT)
  `TES_ASSERT_NOW(a_degen_zero, out_valid && degenerate,
                  step_x == 32'd0 && step_z == 32'd0 && step_w == 32'd0)
  `TES_ASSERT_NEXT(a_last_done, out_acc && last, !out_valid && vertex_count == 2'd0)

endmodule
